>>> sv/nrat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_pkg
// Shared types and constants of the neighbor rssi averaging table.
// ----------------------------------------------------------------------------
package nrat_pkg;

   // field widths
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned FREQ_W   = 5;
   localparam int unsigned BSIC_W   = 6;
   localparam int unsigned RSSI_W   = 8;
   localparam int unsigned AVG_W    = 9;
   localparam int unsigned CNT_W    = 4;

   // table geometry
   localparam int unsigned DEF_FREQ_SLOTS = 32;
   localparam int unsigned BSIC_SLOTS     = 64;

   // result on a first sighting
   localparam logic signed [AVG_W-1:0] FIRST_SIGHTING = -9'sd200;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_REPORT_WINDOW = 1'b0;
   localparam logic [CNT_W-1:0] REPORT_WINDOW_RESET = 4'd4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_START = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD,
      ST_DECAY,
      ST_DRAIN,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic add_read;
      logic add_write;
      logic decay_read;
      logic clear_write;
      logic load_rsp;
      logic rsp_add;
   } dp_cmd_type;

   typedef struct packed {
      logic req_add;
      logic req_start;
      logic req_clear;
      logic sweep_last;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> sv/nrat_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_req_if
// Request channel: one table action per transaction.
// ----------------------------------------------------------------------------
interface nrat_req_if;
   import nrat_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic [FREQ_W-1:0]        freq_index;
   logic [BSIC_W-1:0]        bsic;
   logic signed [RSSI_W-1:0] rssi;

   modport source (output valid, output action, output freq_index, output bsic,
                   output rssi, input ready);
   modport sink   (input valid, input action, input freq_index, input bsic,
                   input rssi, output ready);
endinterface
`default_nettype wire

>>> sv/nrat_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_rsp_if
// Response channel: one averaged level per transaction.
// ----------------------------------------------------------------------------
interface nrat_rsp_if;
   import nrat_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [AVG_W-1:0] avg_rssi;

   modport source (output valid, output avg_rssi, input ready);
   modport sink   (input valid, input avg_rssi, output ready);
endinterface
`default_nettype wire

>>> sv/neighbor_rssi_averaging_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_rssi_averaging_table_core
// Neighbor table keeping a presence count and an averaged level per entry.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one action per transaction: add a measurement for the
//    entry (freq_index, bsic), start a new report (decay all counts) or clear
//    the table. rsp_if returns exactly one avg_rssi per request transaction.
//  - csr_* is an APB-style port; register report_window sits at byte 0.
//  - add: the count and average memories are read on acceptance; in ST_ADD,
//    once rsp_free, the result is registered and written back, then req_ready
//    returns in ST_IDLE: a new add waits for the last one's read-modify-write.
//  - start: a read/writeback sweep over all FREQ_SLOTS*64 entries through
//    ST_DECAY and ST_DRAIN. clear: a write sweep over them in ST_CLEAR.
//    Other action codes and out-of-range adds return 0 from ST_DONE once
//    rsp_free, and req_ready returns in ST_IDLE after that.
//  - reset: a clearing pass writes zero counts to all FREQ_SLOTS*64 entries
//    (2048 by default); req_ready stays low meanwhile, csr writes still work.
//  - the response register lets a finished result wait while the next
//    request is taken; a following result waits until rsp_ready frees it.
// ----------------------------------------------------------------------------
module neighbor_rssi_averaging_table_core #(
   parameter int unsigned FREQ_SLOTS = nrat_pkg::DEF_FREQ_SLOTS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   nrat_req_if.sink                                 req_if,
   nrat_rsp_if.source                               rsp_if,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [nrat_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [nrat_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [nrat_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import nrat_pkg::*;

   logic [CNT_W-1:0] window_ff, window_in;
   logic             csr_hit;
   dp_cmd_type       cmd;
   dp_status_type    status;

   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == CSR_REPORT_WINDOW;
   assign csr_pready = 1'b1;

   always_comb begin
      window_in = window_ff;
      if (csr_psel & csr_penable & csr_pwrite & csr_hit) begin
         window_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= REPORT_WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign csr_prdata = csr_hit ? {{(CSR_DATA_W - CNT_W){1'b0}}, window_ff} : '0;

   nrat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nrat_datapath #(
      .FREQ_SLOTS (FREQ_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_if.action),
      .req_freq_index (req_if.freq_index),
      .req_bsic       (req_if.bsic),
      .req_rssi       (req_if.rssi),
      .report_window  (window_ff),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_avg_rssi   (rsp_if.avg_rssi)
   );
endmodule
`default_nettype wire

>>> sv/nrat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nrat_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> sv/nrat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_ctrl
// Controller: sequences add, decay sweep, clear sweep and the reset clear.
// ----------------------------------------------------------------------------
module nrat_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire nrat_pkg::dp_status_type status,
   output nrat_pkg::dp_cmd_type        cmd
);
   import nrat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (status.req_add) begin
                  state_in = ST_ADD;
               end else if (status.req_start) begin
                  state_in = ST_DECAY;
               end else if (status.req_clear) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADD: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DECAY: begin
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_write = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.capture  = req_valid;
            cmd.add_read = req_valid & status.req_add;
         end
         ST_ADD: begin
            cmd.add_write = status.rsp_free;
            cmd.load_rsp  = status.rsp_free;
            cmd.rsp_add   = 1'b1;
         end
         ST_DECAY: begin
            cmd.decay_read = 1'b1;
         end
         ST_DRAIN: begin
            // last decrement written by the datapath pipeline
         end
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

>>> sv/nrat_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrat_datapath
// Count and average memories, sweep counter, averaging and response register.
// ----------------------------------------------------------------------------
module nrat_datapath #(
   parameter int unsigned FREQ_SLOTS = nrat_pkg::DEF_FREQ_SLOTS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire nrat_pkg::dp_cmd_type                 cmd,
   output nrat_pkg::dp_status_type                   status,
   input  wire logic [nrat_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [nrat_pkg::FREQ_W-1:0]          req_freq_index,
   input  wire logic [nrat_pkg::BSIC_W-1:0]          req_bsic,
   input  wire logic signed [nrat_pkg::RSSI_W-1:0]   req_rssi,
   input  wire logic [nrat_pkg::CNT_W-1:0]           report_window,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [nrat_pkg::AVG_W-1:0]         rsp_avg_rssi
);
   import nrat_pkg::*;

   localparam int unsigned DEPTH  = FREQ_SLOTS * BSIC_SLOTS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [FREQ_W+1:0] FREQ_LIM  = (FREQ_W + 2)'(FREQ_SLOTS);

   // halve toward zero
   function automatic logic signed [RSSI_W-1:0] half(input logic signed [RSSI_W-1:0] x);
      logic signed [RSSI_W-1:0] biased;
      biased = x + RSSI_W'(x[RSSI_W-1]);
      return biased >>> 1;
   endfunction

   logic [FREQ_W+BSIC_W:0]   key_full;
   logic [ADDR_W-1:0]        req_key;
   logic                     req_in_range;

   logic [ADDR_W-1:0]        key_ff;
   logic signed [RSSI_W-1:0] rssi_ff;
   logic [ADDR_W-1:0]        sweep_ff, sweep_in;
   logic                     pend_ff;
   logic [ADDR_W-1:0]        dec_addr_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_W-1:0]  rsp_avg_ff, rsp_avg_in;

   logic                     cnt_we;
   logic [ADDR_W-1:0]        cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]         cnt_wdata, cnt_rdata, cnt_dec;
   logic [RSSI_W-1:0]        avg_rdata;
   logic signed [RSSI_W-1:0] avg_old, avg_new;
   logic                     first_sighting;
   logic signed [AVG_W-1:0]  add_result;
   logic                     sweep_last;

   assign key_full     = {1'b0, req_freq_index, req_bsic};
   assign req_key      = key_full[ADDR_W-1:0];
   assign req_in_range = {2'b00, req_freq_index} < FREQ_LIM;
   assign sweep_last   = sweep_ff == LAST_ADDR;

   assign status.req_add    = (req_action == ACT_ADD) & req_in_range;
   assign status.req_start  = req_action == ACT_START;
   assign status.req_clear  = req_action == ACT_CLEAR;
   assign status.sweep_last = sweep_last;
   assign status.rsp_free   = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= req_key;
         rssi_ff <= req_rssi;
      end
      dec_addr_ff <= sweep_ff;
      rsp_avg_ff  <= rsp_avg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         pend_ff      <= cmd.decay_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.decay_read | cmd.clear_write) begin
         sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   // count memory write port: add update, decay writeback, clear sweep
   assign cnt_dec   = (cnt_rdata == '0) ? '0 : cnt_rdata - 1'b1;
   assign cnt_we    = cmd.add_write | pend_ff | cmd.clear_write;
   assign cnt_raddr = cmd.add_read ? req_key : sweep_ff;

   always_comb begin
      priority if (cmd.add_write) begin
         cnt_waddr = key_ff;
         cnt_wdata = report_window;
      end else if (pend_ff) begin
         cnt_waddr = dec_addr_ff;
         cnt_wdata = cnt_dec;
      end else begin
         cnt_waddr = sweep_ff;
         cnt_wdata = '0;
      end
   end

   nrat_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cmd.add_read | cmd.decay_read),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   nrat_ram #(
      .WIDTH (RSSI_W),
      .DEPTH (DEPTH)
   ) u_avg_ram (
      .clock (clock),
      .we    (cmd.add_write),
      .waddr (key_ff),
      .wdata (avg_new),
      .re    (cmd.add_read),
      .raddr (req_key),
      .rdata (avg_rdata)
   );

   assign avg_old        = avg_rdata;
   assign first_sighting = cnt_rdata == '0;
   assign avg_new        = first_sighting ? rssi_ff : half(rssi_ff) + half(avg_old);
   assign add_result     = first_sighting ? FIRST_SIGHTING : {avg_new[RSSI_W-1], avg_new};

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = cmd.rsp_add ? add_result : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_avg_rssi = rsp_avg_ff;
endmodule
`default_nettype wire

>>> verif/neighbor_rssi_averaging_table_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_rssi_averaging_table_core_tb
// Self-checking bench for the neighbor rssi averaging table. A queue-fed
// driver offers add, start, clear and unused actions in random bursts, a
// shadow copy of the count and average table predicts every response, and
// a monitor with its own stall pattern checks each response in order.
// ----------------------------------------------------------------------------
module neighbor_rssi_averaging_table_core_tb;
   import nrat_pkg::*;

   localparam int unsigned FREQ_SLOTS     = DEF_FREQ_SLOTS;
   localparam int unsigned TABLE_DEPTH    = FREQ_SLOTS * BSIC_SLOTS;
   localparam int unsigned HOT_KEYS       = 12;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 12000;
   localparam int unsigned PHASE_ITEMS    = 234;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [ACTION_W-1:0]      act;
      logic [FREQ_W-1:0]        freq;
      logic [BSIC_W-1:0]        bsic;
      logic signed [RSSI_W-1:0] rssi;
   } nbr_item_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   nrat_req_if req_bus ();
   nrat_rsp_if rsp_bus ();

   neighbor_rssi_averaging_table_core #(
      .FREQ_SLOTS(FREQ_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // shadow table
   logic [CNT_W-1:0]         report_window;
   logic [CNT_W-1:0]         presence_cnt [TABLE_DEPTH];
   logic signed [RSSI_W-1:0] level_mem    [TABLE_DEPTH];

   nbr_item_type             pending_items [$];
   logic signed [AVG_W-1:0]  expected_avg  [$];
   int unsigned              hot_key [HOT_KEYS];

   int unsigned mismatches;
   int unsigned idle_cycles;
   bit          sender_steady;
   bit          rsp_steady;
   int unsigned hold_requests;

   // driver state
   int unsigned             burst_left;
   int unsigned             gap_left;
   logic                    next_valid;
   logic                    req_taken;
   nbr_item_type            taken_item;

   // monitor state
   int unsigned             hold_seen;
   int unsigned             hold_left;
   logic [7:0]              ready_mask;
   logic                    next_ready;
   logic signed [AVG_W-1:0] want_avg;

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // applies one action to the shadow table and returns the predicted level
   function automatic logic signed [AVG_W-1:0] apply_table_action(nbr_item_type it);
      int unsigned             key;
      int                      lvl;
      logic signed [AVG_W-1:0] res;
      res = '0;
      case (it.act)
         ACT_ADD: begin
            if (it.freq < FREQ_SLOTS) begin
               key = it.freq * BSIC_SLOTS + it.bsic;
               if (presence_cnt[key] == 0) begin
                  level_mem[key]    = it.rssi;
                  presence_cnt[key] = report_window;
                  res               = FIRST_SIGHTING;
               end else begin
                  // both halves truncate toward zero
                  lvl               = int'(it.rssi) / 2 + int'(level_mem[key]) / 2;
                  presence_cnt[key] = report_window;
                  level_mem[key]    = lvl[RSSI_W-1:0];
                  res               = lvl[AVG_W-1:0];
               end
            end
         end
         ACT_START: begin
            for (key = 0; key < TABLE_DEPTH; key++) begin
               if (presence_cnt[key] != 0) presence_cnt[key]--;
            end
         end
         ACT_CLEAR: begin
            for (key = 0; key < TABLE_DEPTH; key++) presence_cnt[key] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic nbr_item_type make_item(logic [ACTION_W-1:0] act, int unsigned freq,
                                              int unsigned bsic, int rssi);
      nbr_item_type it;
      it.act  = act;
      it.freq = freq[FREQ_W-1:0];
      it.bsic = bsic[BSIC_W-1:0];
      it.rssi = rssi[RSSI_W-1:0];
      return it;
   endfunction

   // mostly adds on a small pool of entries so repeat sightings are common
   function automatic nbr_item_type random_item();
      nbr_item_type it;
      int unsigned  pick;
      int unsigned  slot;
      pick    = $urandom_range(0, 99);
      it.freq = FREQ_W'($urandom);
      it.bsic = BSIC_W'($urandom);
      it.rssi = RSSI_W'($urandom);
      if (pick < 4) begin
         it.act = ACT_START;
      end else if (pick < 5) begin
         it.act = ACT_CLEAR;
      end else if (pick < 7) begin
         it.act = ACT_UNUSED;
      end else begin
         it.act = ACT_ADD;
         if ($urandom_range(0, 99) < 85) begin
            slot = $urandom_range(0, HOT_KEYS - 1);
            if ($urandom_range(0, 19) == 0) begin
               hot_key[slot] = $urandom_range(0, TABLE_DEPTH - 1);
            end
            it.freq = FREQ_W'(hot_key[slot] / BSIC_SLOTS);
            it.bsic = BSIC_W'(hot_key[slot] % BSIC_SLOTS);
         end
         if ($urandom_range(0, 9) == 0) it.rssi = pick[0] ? 8'sh7f : 8'sh80;
      end
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_avg.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_report_window(logic [CNT_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr = {CSR_REPORT_WINDOW, 2'b00};
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      report_window = value;
      // read back through a second setup/access pair
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[CNT_W-1:0] !== report_window) begin
         report_mismatch("report_window readback", int'(csr_prdata[CNT_W-1:0]),
                         int'(report_window));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // first half, then a full drain before the second half
   task automatic random_phase(int unsigned n, bit pressure);
      int unsigned i;
      @(negedge clock);
      for (i = 0; i < n / 2; i++) pending_items.push_back(random_item());
      if (pressure) hold_requests++;
      wait_drained();
      for (i = n / 2; i < n; i++) pending_items.push_back(random_item());
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.action     <= '0;
         req_bus.freq_index <= '0;
         req_bus.bsic       <= '0;
         req_bus.rssi       <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            taken_item = pending_items.pop_front();
            expected_avg.push_back(apply_table_action(taken_item));
         end
         next_valid = 1'b0;
         if (req_bus.valid && !req_taken) begin
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() != 0) begin
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0 && !sender_steady) gap_left = $urandom_range(1, 12);
            next_valid         = 1'b1;
            req_bus.action     <= pending_items[0].act;
            req_bus.freq_index <= pending_items[0].freq;
            req_bus.bsic       <= pending_items[0].bsic;
            req_bus.rssi       <= pending_items[0].rssi;
         end
         req_bus.valid <= next_valid;
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_seen  = 0;
         hold_left  = 0;
         ready_mask = 8'b1011_0111;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_avg.size() == 0) begin
               report_mismatch("avg_rssi with no transaction pending",
                               int'($signed(rsp_bus.avg_rssi)), 0);
            end else begin
               want_avg = expected_avg.pop_front();
               if (rsp_bus.avg_rssi !== want_avg) begin
                  report_mismatch("avg_rssi", int'($signed(rsp_bus.avg_rssi)), int'(want_avg));
               end
            end
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (rsp_steady) begin
            next_ready = 1'b1;
         end else begin
            next_ready = ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[7:1]};
            if ($urandom_range(0, 63) == 0) ready_mask = 8'($urandom_range(1, 255));
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // no transaction on either side for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned k;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      mismatches         = 0;
      sender_steady      = 1'b0;
      rsp_steady         = 1'b0;
      hold_requests      = 0;
      report_window      = REPORT_WINDOW_RESET;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         presence_cnt[k] = '0;
         level_mem[k]    = '0;
      end
      for (k = 0; k < HOT_KEYS; k++) hot_key[k] = $urandom_range(0, TABLE_DEPTH - 1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, truncation of negative halves, expiry, clear
      @(negedge clock);
      pending_items.push_back(make_item(ACT_ADD, 0, 0, -128));
      pending_items.push_back(make_item(ACT_ADD, 0, 0, 127));
      pending_items.push_back(make_item(ACT_ADD, 31, 63, 127));
      pending_items.push_back(make_item(ACT_ADD, 31, 63, -128));
      pending_items.push_back(make_item(ACT_ADD, 31, 63, -3));
      pending_items.push_back(make_item(ACT_ADD, 21, 42, -1));
      pending_items.push_back(make_item(ACT_ADD, 10, 21, 0));
      pending_items.push_back(make_item(ACT_ADD, 10, 21, 85));
      pending_items.push_back(make_item(ACT_UNUSED, 31, 63, -1));
      for (k = 0; k < 4; k++) pending_items.push_back(make_item(ACT_START, 0, 0, 0));
      // window of 4 has run out for every entry: first sighting again
      pending_items.push_back(make_item(ACT_ADD, 0, 0, -86));
      pending_items.push_back(make_item(ACT_ADD, 0, 0, -5));
      pending_items.push_back(make_item(ACT_START, 31, 63, 127));
      pending_items.push_back(make_item(ACT_CLEAR, 31, 63, -128));
      pending_items.push_back(make_item(ACT_ADD, 0, 0, 1));
      pending_items.push_back(make_item(ACT_START, 0, 0, 0));
      pending_items.push_back(make_item(ACT_START, 0, 0, 0));
      wait_drained();

      // zero window: every sighting counts as a first one
      set_report_window(4'd0);
      @(negedge clock);
      pending_items.push_back(make_item(ACT_ADD, 5, 5, 10));
      pending_items.push_back(make_item(ACT_ADD, 5, 5, 20));
      pending_items.push_back(make_item(ACT_START, 5, 5, 0));
      pending_items.push_back(make_item(ACT_ADD, 5, 5, -20));
      wait_drained();

      set_report_window(4'd15);
      random_phase(PHASE_ITEMS, 1'b1);
      set_report_window(4'd1);
      random_phase(PHASE_ITEMS, 1'b0);
      sender_steady = 1'b1;
      rsp_steady    = 1'b1;
      set_report_window(4'd7);
      random_phase(PHASE_ITEMS, 1'b0);
      sender_steady = 1'b0;
      rsp_steady    = 1'b0;
      set_report_window(4'd0);
      random_phase(PHASE_ITEMS, 1'b0);
      set_report_window(4'd4);
      random_phase(PHASE_ITEMS, 1'b1);
      set_report_window(CNT_W'($urandom_range(1, 15)));
      random_phase(PHASE_ITEMS, 1'b0);

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_avg.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
sv/nrat_pkg.sv
sv/nrat_req_if.sv
sv/nrat_rsp_if.sv
sv/nrat_ram.sv
sv/nrat_ctrl.sv
sv/nrat_datapath.sv
sv/neighbor_rssi_averaging_table_core.sv
verif/neighbor_rssi_averaging_table_core_tb.sv
